FILE: hdl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared widths, constants, state types and control structs of the sliding
// window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  // Ring depth default.
  localparam int NumSlotsDefault = 16;

  // Field widths.
  localparam int CountW   = 32;
  localparam int TimeW    = 64;
  localparam int DurW     = 48;
  localparam int PktSumW  = 40;
  localparam int DurSumW  = 56;
  localparam int RateW    = 48;
  localparam int CfgDataW = 48;

  // Stored ring entry: packet count above, duration below.
  localparam int EntryW = CountW + DurW;

  // Bitrate product: total packets times bits per packet times 1e9.
  localparam int ConstW = 41;
  localparam logic [ConstW-1:0] BitsTimesNs = 41'd1504000000000;
  localparam int HalfW  = PktSumW / 2;
  localparam int PartW  = HalfW + ConstW;
  localparam int ProdW  = PktSumW + ConstW;
  localparam int CntW   = $clog2(RateW + 1);

  localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};
  localparam logic [DurW-1:0]  DurMax  = {DurW{1'b1}};

  // Register reset values.
  localparam logic [CountW-1:0] MinPacketsReset  = 32'd10000;
  localparam logic [DurW-1:0]   MinIntervalReset = 48'd50000000;

  // Configuration register indexes.
  localparam logic CfgMinPackets  = 1'b0;
  localparam logic CfgMinInterval = 1'b1;

  // Operation codes.
  localparam logic OpReport  = 1'b0;
  localparam logic OpRestart = 1'b1;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_APPLY,
    ST_RATE,
    ST_WAIT,
    ST_DONE
  } swrm_state_e;

  // Bitrate unit states.
  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_MUL_LO,
    DIV_MUL_HI,
    DIV_CHECK,
    DIV_RUN,
    DIV_DONE
  } swrm_div_state_e;

  // Request to the bitrate unit.
  typedef struct packed {
    logic               start;
    logic [PktSumW-1:0] packets;
    logic [DurSumW-1:0] duration;
  } swrm_div_req_t;

  // Answer from the bitrate unit.
  typedef struct packed {
    logic             done;
    logic [RateW-1:0] bitrate;
  } swrm_div_rsp_t;

endpackage

FILE: hdl/sliding_window_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Sequence: an input transfer is captured and handled in the calc state (a restart
// clears the meter); when the budget runs out, the clock is examined in the decide
// state and a long enough interval is stored in the apply state; then the bitrate
// unit runs, dividing only when the bitrate is neither zero nor saturated.
// Throughput: one item at a time; a new input waits for the output register.
// Reset: totals, ring valid bits, slot pointer and origins clear at once;
// registers take their reset values; the ring RAM itself is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter
  import swrm_pkg::*;
#(
  parameter int NumSlots = NumSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [CountW-1:0]   packet_count_i,
  input  logic [TimeW-1:0]    now_ns_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                clock_checked_o,
  output logic [PktSumW-1:0]  total_packets_o,
  output logic [DurSumW-1:0]  total_duration_ns_o,
  output logic [RateW-1:0]    bitrate_bps_o
);

  localparam int SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  swrm_state_e state_q, state_d;

  // Configuration registers.
  logic [CountW-1:0] min_packets_q;
  logic [DurW-1:0]   min_interval_q;

  // Captured input item.
  logic              op_q, op_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  now_q, now_d;

  // Meter state.
  logic [TimeW-1:0]    session_origin_q, session_origin_d;
  logic [TimeW-1:0]    interval_origin_q, interval_origin_d;
  logic [CountW-1:0]   interval_packets_q, interval_packets_d;
  logic [CountW-1:0]   budget_q, budget_d;
  logic [SlotW-1:0]    next_slot_q, next_slot_d;
  logic [NumSlots-1:0] slot_valid_q, slot_valid_d;
  logic [PktSumW-1:0]  sum_packets_q, sum_packets_d;
  logic [DurSumW-1:0]  sum_duration_q, sum_duration_d;

  // Per-item working registers.
  logic              checked_q, checked_d;
  logic [TimeW-1:0]  in_session_q, in_session_d;
  logic [DurW-1:0]   len_q, len_d;
  logic [CountW-1:0] old_packets_q, old_packets_d;
  logic [DurW-1:0]   old_duration_q, old_duration_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic               out_checked_q, out_checked_d;
  logic [PktSumW-1:0] out_packets_q, out_packets_d;
  logic [DurSumW-1:0] out_duration_q, out_duration_d;
  logic [RateW-1:0]   out_rate_q, out_rate_d;

  // Ring RAM port signals.
  logic              ram_we, ram_re;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  // Bitrate unit.
  swrm_div_req_t div_req;
  swrm_div_rsp_t div_rsp;

  // Intermediate values.
  logic [CountW:0]   ip_sum;
  logic [CountW-1:0] budget_after;
  logic [TimeW-1:0]  len_full;
  logic              too_short;
  logic [CountW-1:0] half_budget;
  logic [SlotW-1:0]  slot_after;

  logic in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign ip_sum       = {1'b0, interval_packets_q} + {1'b0, count_q};
  assign budget_after = (count_q >= budget_q) ? '0 : (budget_q - count_q);
  assign len_full     = in_session_q - interval_origin_q;
  assign too_short    = len_full[TimeW-1] ||
                        (len_full < {{(TimeW-DurW){1'b0}}, min_interval_q});
  assign half_budget  = min_packets_q >> 1;
  assign slot_after   = (next_slot_q == SlotW'(NumSlots - 1)) ? '0
                                                              : next_slot_q + SlotW'(1);

  assign ram_wdata = {interval_packets_q, len_q};

  assign div_req.start    = (state_q == ST_RATE);
  assign div_req.packets  = sum_packets_q;
  assign div_req.duration = sum_duration_q;

  // Ring storage: one entry per stored interval.
  swrm_ram #(
    .Width(EntryW),
    .Depth(NumSlots)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_slot_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(next_slot_q),
    .rdata_o(ram_rdata)
  );

  swrm_divider u_divider (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Item sequencer: count or restart; on a check read the oldest entry, decide and write back; then rate.
  always_comb begin
    state_d            = state_q;
    op_d               = op_q;
    count_d            = count_q;
    now_d              = now_q;
    session_origin_d   = session_origin_q;
    interval_origin_d  = interval_origin_q;
    interval_packets_d = interval_packets_q;
    budget_d           = budget_q;
    next_slot_d        = next_slot_q;
    slot_valid_d       = slot_valid_q;
    sum_packets_d      = sum_packets_q;
    sum_duration_d     = sum_duration_q;
    checked_d          = checked_q;
    in_session_d       = in_session_q;
    len_d              = len_q;
    old_packets_d      = old_packets_q;
    old_duration_d     = old_duration_q;
    out_valid_d        = out_valid_q && !out_ready_i;
    out_checked_d      = out_checked_q;
    out_packets_d      = out_packets_q;
    out_duration_d     = out_duration_q;
    out_rate_d         = out_rate_q;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = operation_i;
          count_d = packet_count_i;
          now_d   = now_ns_i;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (op_q == OpRestart) begin
          session_origin_d   = now_q;
          interval_origin_d  = '0;
          interval_packets_d = '0;
          budget_d           = min_packets_q;
          next_slot_d        = '0;
          slot_valid_d       = '0;
          sum_packets_d      = '0;
          sum_duration_d     = '0;
          checked_d          = 1'b0;
          state_d            = ST_RATE;
        end else begin
          // Saturating interval count and budget countdown.
          interval_packets_d = ip_sum[CountW] ? {CountW{1'b1}} : ip_sum[CountW-1:0];
          budget_d           = budget_after;
          if (budget_after == '0) begin
            checked_d    = 1'b1;
            in_session_d = now_q - session_origin_q;
            ram_re       = 1'b1;
            state_d      = ST_DECIDE;
          end else begin
            checked_d = 1'b0;
            state_d   = ST_RATE;
          end
        end
      end
      ST_DECIDE: begin
        // A never written entry reads as zero.
        old_packets_d  = slot_valid_q[next_slot_q] ? ram_rdata[EntryW-1:DurW] : '0;
        old_duration_d = slot_valid_q[next_slot_q] ? ram_rdata[DurW-1:0] : '0;
        if (too_short) begin
          budget_d = (half_budget == '0) ? CountW'(1) : half_budget;
          state_d  = ST_RATE;
        end else begin
          len_d   = (len_full[TimeW-1:DurW] != '0) ? DurMax : len_full[DurW-1:0];
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // Replace the oldest entry and move the totals with it.
        ram_we                    = 1'b1;
        slot_valid_d[next_slot_q] = 1'b1;
        next_slot_d               = slot_after;
        sum_packets_d  = sum_packets_q - PktSumW'(old_packets_q)
                         + PktSumW'(interval_packets_q);
        sum_duration_d = sum_duration_q - DurSumW'(old_duration_q) + DurSumW'(len_q);
        interval_origin_d  = in_session_q;
        interval_packets_d = '0;
        state_d            = ST_RATE;
      end
      ST_RATE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the output register once it is free or being drained.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_checked_d  = checked_q;
          out_packets_d  = sum_packets_q;
          out_duration_d = sum_duration_q;
          out_rate_d     = div_rsp.bitrate;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and meter state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      min_packets_q      <= MinPacketsReset;
      min_interval_q     <= MinIntervalReset;
      session_origin_q   <= '0;
      interval_origin_q  <= '0;
      interval_packets_q <= '0;
      budget_q           <= MinPacketsReset;
      next_slot_q        <= '0;
      slot_valid_q       <= '0;
      sum_packets_q      <= '0;
      sum_duration_q     <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      state_q            <= state_d;
      session_origin_q   <= session_origin_d;
      interval_origin_q  <= interval_origin_d;
      interval_packets_q <= interval_packets_d;
      budget_q           <= budget_d;
      next_slot_q        <= next_slot_d;
      slot_valid_q       <= slot_valid_d;
      sum_packets_q      <= sum_packets_d;
      sum_duration_q     <= sum_duration_d;
      out_valid_q        <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgMinPackets:  min_packets_q  <= cfg_data_i[CountW-1:0];
          CfgMinInterval: min_interval_q <= cfg_data_i[DurW-1:0];
          default:        min_packets_q  <= min_packets_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q           <= op_d;
    count_q        <= count_d;
    now_q          <= now_d;
    checked_q      <= checked_d;
    in_session_q   <= in_session_d;
    len_q          <= len_d;
    old_packets_q  <= old_packets_d;
    old_duration_q <= old_duration_d;
    out_checked_q  <= out_checked_d;
    out_packets_q  <= out_packets_d;
    out_duration_q <= out_duration_d;
    out_rate_q     <= out_rate_d;
  end

  assign out_valid_o         = out_valid_q;
  assign clock_checked_o     = out_checked_q;
  assign total_packets_o     = out_packets_q;
  assign total_duration_ns_o = out_duration_q;
  assign bitrate_bps_o       = out_rate_q;

  // The bitrate unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_WAIT))
    else $error("bitrate unit finished outside the wait state");

  // A ring write is never issued together with a ring read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring read and write overlap");

  // The slot pointer stays inside the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= SlotW'(NumSlots - 1))
    else $error("slot pointer out of range");

  // A zero duration reports a zero bitrate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (total_duration_ns_o == '0)) |-> (bitrate_bps_o == '0))
    else $error("nonzero bitrate with zero duration");

endmodule

FILE: hdl/swrm_ram.sv
// ----------------------------------------------------------------------------
// swrm_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module swrm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/swrm_divider.sv
// ----------------------------------------------------------------------------
// swrm_divider
// Bitrate unit: multiplies the packet total by bits per packet times 1e9 in
// two partial products, then divides by the duration one quotient bit per
// cycle, saturating at the bitrate field maximum; a zero duration gives zero.
// ----------------------------------------------------------------------------
module swrm_divider
  import swrm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  swrm_div_req_t req_i,
  output swrm_div_rsp_t rsp_o
);

  swrm_div_state_e    state_q, state_d;
  logic [PktSumW-1:0] pk_q, pk_d;
  logic [DurSumW-1:0] dur_q, dur_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [DurSumW-1:0] rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [RateW-1:0]   rate_q, rate_d;

  logic [PartW-1:0]         part_lo, part_hi;
  logic [DurSumW:0]         trial, diff;
  logic                     take;
  logic [ProdW-RateW-1:0]   prod_top;

  // One restoring division step and the two partial products.
  assign part_lo  = PartW'(pk_q[HalfW-1:0]) * PartW'(BitsTimesNs);
  assign part_hi  = PartW'(pk_q[PktSumW-1:HalfW]) * PartW'(BitsTimesNs);
  assign trial    = {rem_q, prod_q[RateW-1]};
  assign diff     = trial - {1'b0, dur_q};
  assign take     = (trial >= {1'b0, dur_q});
  assign prod_top = prod_q[ProdW-1:RateW];

  // Sequencer of the unit.
  always_comb begin
    state_d = state_q;
    pk_d    = pk_q;
    dur_d   = dur_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    rate_d  = rate_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          pk_d    = req_i.packets;
          dur_d   = req_i.duration;
          state_d = DIV_MUL_LO;
        end
      end
      DIV_MUL_LO: begin
        prod_d  = ProdW'(part_lo);
        state_d = DIV_MUL_HI;
      end
      DIV_MUL_HI: begin
        prod_d  = prod_q + (ProdW'(part_hi) << HalfW);
        state_d = DIV_CHECK;
      end
      DIV_CHECK: begin
        // A quotient of 2^48 or more shows already in the upper product bits.
        if (dur_q == '0) begin
          rate_d  = '0;
          state_d = DIV_DONE;
        end else if (DurSumW'(prod_top) >= dur_q) begin
          rate_d  = RateMax;
          state_d = DIV_DONE;
        end else begin
          rem_d   = DurSumW'(prod_top);
          cnt_d   = CntW'(RateW);
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        // The low product bits shift out while quotient bits shift in.
        rem_d              = take ? diff[DurSumW-1:0] : trial[DurSumW-1:0];
        prod_d[RateW-1:0]  = {prod_q[RateW-2:0], take};
        cnt_d              = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          rate_d  = {prod_q[RateW-2:0], take};
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pk_q   <= pk_d;
    dur_q  <= dur_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    rate_q <= rate_d;
  end

  assign rsp_o.done    = (state_q == DIV_DONE);
  assign rsp_o.bitrate = rate_q;

endmodule
